[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; every property is clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/dhp_pkg.sv]
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared constants and types of the dew heater time-proportional controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dhp_pkg;

  localparam int WINDOW_MS_DEF = 5000;

  localparam int TENTHS_W  = 9;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int DVS_W     = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EN   = 2'd3;

  localparam logic signed [TENTHS_W-1:0] TENTHS_MIN = -9'sd50;
  localparam logic signed [TENTHS_W-1:0] TENTHS_MAX = 9'sd200;
  localparam logic signed [TENTHS_W-1:0] ZERO_RST   = -9'sd50;
  localparam logic signed [TENTHS_W-1:0] SPAN_RST   = 9'sd200;

  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0] PCT_RST    = 7'd100;
  localparam logic [PCT_W-1:0] ROUND_HALF = 7'd50;

  typedef struct packed {
    logic signed [TENTHS_W-1:0] zero_tenths;
    logic signed [TENTHS_W-1:0] span_tenths;
    logic [PCT_W-1:0]           max_power_pct;
    logic                       heater_enabled;
    logic                       en_wr;          // enable register written this cycle
  } cfg_t;

endpackage

`default_nettype wire

[rtl/dhp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dhp_cfg_regs
// Configuration registers with range check and zero/span ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module dhp_cfg_regs
  import dhp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [TENTHS_W-1:0]  wr_data,
  output cfg_t                      cfg_q
);

  logic signed [TENTHS_W-1:0] zero_r, zero_nxt;
  logic signed [TENTHS_W-1:0] span_r, span_nxt;
  logic [PCT_W-1:0]           pct_r, pct_nxt;
  logic                       en_r, en_nxt;
  logic signed [TENTHS_W-1:0] wval;
  logic                       in_rng;

  assign wval   = signed'(wr_data);
  assign in_rng = (wval >= TENTHS_MIN) && (wval <= TENTHS_MAX);

  always_comb begin
    zero_nxt = zero_r;
    span_nxt = span_r;
    pct_nxt  = pct_r;
    en_nxt   = en_r;
    if (wr_en) begin
      case (wr_index)
        CFG_ZERO: begin
          if (in_rng) zero_nxt = (wval >= span_r) ? span_r - 9'sd1 : wval;
        end
        CFG_SPAN: begin
          if (in_rng) span_nxt = (wval <= zero_r) ? zero_r + 9'sd1 : wval;
        end
        CFG_PCT: pct_nxt = wr_data[PCT_W-1:0];
        CFG_EN:  en_nxt  = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= ZERO_RST;
      span_r <= SPAN_RST;
      pct_r  <= PCT_RST;
      en_r   <= 1'b0;
    end else begin
      zero_r <= zero_nxt;
      span_r <= span_nxt;
      pct_r  <= pct_nxt;
      en_r   <= en_nxt;
    end
  end

  always_comb begin
    cfg_q.zero_tenths    = zero_r;
    cfg_q.span_tenths    = span_r;
    cfg_q.max_power_pct  = pct_r;
    cfg_q.heater_enabled = en_r;
    cfg_q.en_wr          = wr_en && (wr_index == CFG_EN);
  end

endmodule

`default_nettype wire

[rtl/dhp_div.sv]
// ----------------------------------------------------------------------------
// dhp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dhp_div
  import dhp_pkg::*;
#(
  parameter int DVD_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // quo_r shifts the dividend out at the top and the quotient in at the bottom
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  assign quo_nxt = {quo_r[DVD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/dew_heater_time_proportional_pwm_top.sv]
// ----------------------------------------------------------------------------
// dew_heater_time_proportional_pwm_top
// Dew heater controller: margin to on-time map, power cap, windowed PWM.
// Item handling: an invalid or disabled item goes straight to the result; a
// margin outside zero..span takes one pass of the bit-serial divider (power
// cap), any other margin two passes (margin map, then power cap).
// The result becomes valid in the same cycle that the next item can be taken.
// Reset (sync, rst_n low) restores default registers, window start zero,
// heater off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dew_heater_time_proportional_pwm_top
  import dhp_pkg::*;
#(
  parameter int WINDOW_MS = WINDOW_MS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          in_now_ms,
  input  wire logic signed [15:0]   in_delta_tenths,
  input  wire logic                 in_sensor_invalid,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_heater_on,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TENTHS_W-1:0]  cfg_data
);

  localparam int WIN_W = $clog2(WINDOW_MS + 1);
  localparam int DVD_W = WIN_W + 8;
  localparam logic [WIN_W-1:0] WIN_C = WIN_W'(WINDOW_MS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAP   = 4'd1;
  localparam logic [3:0] S_D1GO  = 4'd2;
  localparam logic [3:0] S_D1WT  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_D2GO  = 4'd5;
  localparam logic [3:0] S_D2WT  = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  cfg_t cfg_q;

  logic [3:0]         state_r;
  logic [31:0]        now_r;
  logic               inv_r;
  logic signed [16:0] d_r;
  logic signed [9:0]  den_r;
  logic [WIN_W-1:0]   on_r;
  logic [WIN_W-1:0]   sw_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [31:0]        lim_win_r, lim_sw_r;
  logic [31:0]        window_start_r;
  logic               heater_state_r;
  logic               out_valid_r, out_heater_on_r;

  logic               in_fire;
  logic               div_start, div_busy, div_done;
  logic [DVD_W-1:0]   div_quo;
  logic signed [16:0] d_nxt;
  logic signed [9:0]  den_nxt;
  logic signed [16:0] den_ext;
  logic [PCT_W-1:0]   pct_eff;
  logic [31:0]        dt_win, dt_sw;
  logic               aft_win, aft_sw;
  logic               out_free;

  dhp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_q    (cfg_q)
  );

  dhp_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign div_start = (state_r == S_D1GO) || (state_r == S_D2GO);
  assign out_free  = !out_valid_r || out_ready;

  assign d_nxt   = 17'(in_delta_tenths) - 17'(cfg_q.zero_tenths);
  assign den_nxt = 10'(cfg_q.span_tenths) - 10'(cfg_q.zero_tenths);
  assign den_ext = 17'(den_r);
  assign pct_eff = (cfg_q.max_power_pct > PCT_FULL) ? PCT_FULL : cfg_q.max_power_pct;

  // wrap-safe "now is after limit": signed difference strictly positive
  assign dt_win  = now_r - lim_win_r;
  assign dt_sw   = now_r - lim_sw_r;
  assign aft_win = (dt_win != 32'd0) && !dt_win[31];
  assign aft_sw  = (dt_sw != 32'd0) && !dt_sw[31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      window_start_r <= '0;
      heater_state_r <= 1'b0;
      out_valid_r    <= 1'b0;
      inv_r          <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) out_valid_r <= 1'b0;
      if (cfg_q.en_wr) heater_state_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            inv_r <= in_sensor_invalid;
            if (in_sensor_invalid) begin
              heater_state_r <= 1'b0;
              state_r        <= S_FIN;
            end else if (!cfg_q.heater_enabled) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_MAP;
            end
          end
        end
        S_MAP: begin
          if (den_r <= 10'sd0 || d_r >= den_ext || d_r <= 17'sd0) begin
            state_r <= S_SCALE;
          end else begin
            state_r <= S_D1GO;
          end
        end
        S_D1GO:  state_r <= S_D1WT;
        S_D1WT:  if (div_done) state_r <= S_SCALE;
        S_SCALE: state_r <= S_D2GO;
        S_D2GO:  state_r <= S_D2WT;
        S_D2WT:  if (div_done) state_r <= S_SUM;
        S_SUM:   state_r <= S_CMP;
        S_CMP: begin
          if (aft_win) begin
            window_start_r <= now_r;
          end else if (!heater_state_r && !aft_sw) begin
            heater_state_r <= 1'b1;
          end else if (heater_state_r && aft_sw) begin
            heater_state_r <= 1'b0;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          now_r <= in_now_ms;
          d_r   <= d_nxt;
          den_r <= den_nxt;
        end
      end
      S_MAP: begin
        // margin at or below zero: full window; at or beyond span: none
        if (den_r <= 10'sd0 || d_r >= den_ext) begin
          on_r <= '0;
        end else if (d_r <= 17'sd0) begin
          on_r <= WIN_C;
        end else begin
          dvd_r <= DVD_W'(d_r[7:0]) * DVD_W'(WIN_C);
          dvs_r <= den_r[DVS_W-1:0];
        end
      end
      S_D1WT: if (div_done) on_r <= WIN_C - div_quo[WIN_W-1:0];
      S_SCALE: begin
        dvd_r <= DVD_W'(on_r) * DVD_W'(pct_eff) + DVD_W'(ROUND_HALF);
        dvs_r <= DVS_W'(PCT_FULL);
      end
      S_D2WT: if (div_done) sw_r <= div_quo[WIN_W-1:0];
      S_SUM: begin
        lim_win_r <= window_start_r + 32'(WIN_C);
        lim_sw_r  <= window_start_r + 32'(sw_r);
      end
      S_FIN: if (out_free) out_heater_on_r <= heater_state_r;
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_heater_on = out_heater_on_r;

  `AST_NXT(a_busy_after_accept, in_fire, state_r != S_IDLE)
  `AST_IMP(a_invalid_forces_off, (state_r == S_FIN) && inv_r, !heater_state_r)
  `AST_IMP(a_div_start_idle, div_start, !div_busy)
  `AST_IMP(a_zero_below_span, 1'b1, cfg_q.zero_tenths < cfg_q.span_tenths)

endmodule

`default_nettype wire

[sim/dew_heater_time_proportional_pwm_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_heater_time_proportional_pwm_top_test
// Self-checking bench for the dew heater PWM controller. A short table of
// directed ticks and register writes runs first. Then come ten phases of
// random settings and random tick streams. Each heater level is checked against
// a typed-in level or an in-bench model of the margin map, the power cap and the window.
// ----------------------------------------------------------------------------

module dew_heater_time_proportional_pwm_top_test;
  import dhp_pkg::*;

  localparam longint WIN_MS     = WINDOW_MS_DEF;
  localparam int     DRAIN_CYC  = 60;
  localparam int     PHASES     = 10;
  localparam int     PHASE_LEN  = 95;
  localparam int     SHOW_MAX   = 10;

  typedef enum logic {ROW_REG, ROW_TICK} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [TENTHS_W-1:0]   data;
    logic [31:0]           now;
    logic [15:0]           delta;
    logic                  bad;
    logic                  typed;  // level below is typed in, not predicted
    logic                  lvl;
  } step_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [31:0]           in_now_ms;
  logic signed [15:0]    in_delta_tenths;
  logic                  in_sensor_invalid;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_heater_on;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [TENTHS_W-1:0]   cfg_data;

  // model state and registers
  int                    zero_t;
  int                    span_t;
  logic [PCT_W-1:0]      pct_reg;
  logic                  en_reg;
  logic [31:0]           win_start;
  logic                  heat;

  logic                  heat_q[$];
  step_row_t             dir_tab[$];
  logic                  lvl_exp;
  logic                  idle_on;
  int                    errors;
  int                    n_items;
  int                    n_writes;
  int                    n_on;

  dew_heater_time_proportional_pwm_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_ms         (in_now_ms),
    .in_delta_tenths   (in_delta_tenths),
    .in_sensor_invalid (in_sensor_invalid),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_heater_on     (out_heater_on),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flag_fail(string msg);
    errors++;
    if (errors <= SHOW_MAX) begin
      $display("%s", msg);
    end
  endfunction

  // wrap-safe: signed value of (a - b) greater than zero
  function automatic logic later_than(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic void heat_reset();
    zero_t    = ZERO_RST;
    span_t    = SPAN_RST;
    pct_reg   = PCT_RST;
    en_reg    = 1'b0;
    win_start = 32'd0;
    heat      = 1'b0;
  endfunction

  function automatic void heat_cfg(logic [CFG_IDX_W-1:0] idx, logic [TENTHS_W-1:0] val);
    int t;
    t = $signed(val);
    case (idx)
      CFG_ZERO: begin
        if (t >= TENTHS_MIN && t <= TENTHS_MAX) begin
          zero_t = (t >= span_t) ? span_t - 1 : t;
        end
      end
      CFG_SPAN: begin
        if (t >= TENTHS_MIN && t <= TENTHS_MAX) begin
          span_t = (t <= zero_t) ? zero_t + 1 : t;
        end
      end
      CFG_PCT: begin
        pct_reg = val[PCT_W-1:0];
      end
      CFG_EN: begin
        heat   = 1'b0;
        en_reg = val[0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic heat_tick(logic [31:0] t, logic signed [15:0] d, logic bad);
    longint      den;
    longint      num;
    longint      on_ms;
    longint      cap;
    logic [31:0] sw;
    if (bad) begin
      heat = 1'b0;
    end else if (en_reg) begin
      den   = longint'(span_t) - longint'(zero_t);
      on_ms = 0;
      cap   = (pct_reg > PCT_FULL) ? longint'(PCT_FULL) : longint'(pct_reg);
      if (den > 0) begin
        num   = (longint'(d) - longint'(zero_t)) * (-WIN_MS);
        on_ms = num / den + WIN_MS;
      end
      if (on_ms < 0) on_ms = 0;
      if (on_ms > WIN_MS) on_ms = WIN_MS;
      sw = 32'((on_ms * cap + longint'(ROUND_HALF)) / longint'(PCT_FULL));
      if (later_than(t, win_start + 32'(WIN_MS))) begin
        win_start = t;  // window restart, level held for this tick
      end else if (!heat && !later_than(t, win_start + sw)) begin
        heat = 1'b1;
      end else if (heat && later_than(t, win_start + sw)) begin
        heat = 1'b0;
      end
    end
    return heat;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [TENTHS_W-1:0] val);
    step_row_t row;
    row       = '0;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.data  = val;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_tick(logic [31:0] t, logic [15:0] d, logic bad,
                                   logic typed, logic lvl);
    step_row_t row;
    row       = '0;
    row.kind  = ROW_TICK;
    row.now   = t;
    row.delta = d;
    row.bad   = bad;
    row.typed = typed;
    row.lvl   = lvl;
    dir_tab.push_back(row);
  endfunction

  task automatic send_tick(input logic [31:0] t, input logic signed [15:0] d,
                           input logic bad, input logic typed, input logic lvl);
    logic pred;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_now_ms         = t;
    in_delta_tenths   = d;
    in_sensor_invalid = bad;
    do @(posedge clk); while (!in_ready);
    pred = heat_tick(t, d, bad);
    heat_q.push_back(typed ? lvl : pred);
    n_items++;
  endtask

  // registers change only with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TENTHS_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (heat_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    heat_cfg(idx, val);
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready = !idle_on || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_heater_on === 1'b1) n_on++;
      if (heat_q.size() == 0) begin
        flag_fail($sformatf("%0t: heater item with nothing pending, got %0b",
                            $time, out_heater_on));
      end else begin
        lvl_exp = heat_q.pop_front();
        if (out_heater_on !== lvl_exp) begin
          flag_fail($sformatf("%0t: heater_on expected %0b got %0b",
                              $time, lvl_exp, out_heater_on));
        end
      end
    end
  end

  initial begin
    logic [31:0]          t;
    logic signed [15:0]   d;
    logic                 bad;
    logic [TENTHS_W-1:0]  val;
    logic [CFG_IDX_W-1:0] ridx;
    logic                 swap;
    int                   r;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_now_ms         = 32'd0;
    in_delta_tenths   = 16'sd0;
    in_sensor_invalid = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_ZERO;
    cfg_data          = '0;
    idle_on           = 1'b1;
    errors            = 0;
    n_items           = 0;
    n_writes          = 0;
    n_on              = 0;
    heat_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    add_tick(32'd0,          16'h0000, 1'b0, 1'b1, 1'b0);  // disabled after reset
    add_tick(32'hFFFF_FFFF,  16'h7FFF, 1'b1, 1'b1, 1'b0);
    add_reg (CFG_EN, 9'd1);
    add_tick(32'd1,          16'h8000, 1'b0, 1'b1, 1'b1);  // lowest margin, full on
    add_tick(32'd100,        16'h7FFF, 1'b0, 1'b1, 1'b0);  // highest margin, no on time
    add_tick(32'd200,        16'hFFCE, 1'b0, 1'b1, 1'b1);  // margin at zero
    add_tick(32'd300,        16'hFFCE, 1'b1, 1'b1, 1'b0);  // invalid sensor
    add_tick(32'd5001,       16'hFFCE, 1'b0, 1'b1, 1'b0);  // window restart
    add_tick(32'd5002,       16'd200,  1'b0, 1'b0, 1'b0);  // margin at span
    add_tick(32'd5003,       16'd75,   1'b0, 1'b0, 1'b0);
    add_tick(32'd7600,       16'd75,   1'b0, 1'b0, 1'b0);
    add_reg (CFG_PCT, 9'd0);
    add_tick(32'd10002,      16'h8000, 1'b0, 1'b0, 1'b0);
    add_tick(32'd10003,      16'h8000, 1'b0, 1'b0, 1'b0);
    add_reg (CFG_PCT, 9'd127);                              // acts as full power
    add_tick(32'd10004,      16'h8000, 1'b0, 1'b0, 1'b0);
    add_reg (CFG_EN, 9'd1);                                 // write clears the heater
    add_reg (CFG_EN, 9'd0);
    add_tick(32'd10005,      16'h8000, 1'b0, 1'b1, 1'b0);
    add_reg (CFG_ZERO, 9'h0FF);                             // 255, out of range
    add_reg (CFG_ZERO, 9'h1CD);                             // -51, out of range
    add_reg (CFG_SPAN, 9'h1CE);                             // span pushed above zero
    add_reg (CFG_ZERO, 9'd200);                             // zero pulled below span
    add_reg (CFG_SPAN, 9'd200);
    add_reg (CFG_ZERO, 9'd200);
    add_reg (CFG_EN, 9'd1);
    add_tick(32'hFFFF_F000,  16'd199,  1'b0, 1'b0, 1'b0);
    add_tick(32'hFFFF_FFFF,  16'd200,  1'b0, 1'b0, 1'b0);
    add_tick(32'h0000_0010,  16'h8000, 1'b0, 1'b0, 1'b0);
    add_tick(32'h8000_0000,  16'h0000, 1'b0, 1'b0, 1'b0);
    add_tick(32'h7FFF_FFFF,  16'h5555, 1'b0, 1'b0, 1'b0);
    add_tick(32'hAAAA_AAAA,  16'hAAAA, 1'b0, 1'b0, 1'b0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_tick(dir_tab[i].now, dir_tab[i].delta, dir_tab[i].bad,
                  dir_tab[i].typed, dir_tab[i].lvl);
      end
    end

    // random phases, fresh settings each
    t = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      swap = $urandom_range(1);
      for (int k = 0; k < 4; k++) begin
        ridx = (k < 2 && swap) ? CFG_IDX_W'(1 - k) : CFG_IDX_W'(k);
        r    = $urandom_range(9);
        case (ridx)
          CFG_ZERO, CFG_SPAN: begin
            if (r == 0) val = TENTHS_MIN;
            else if (r == 1) val = TENTHS_MAX;
            else if (r == 2) val = TENTHS_W'($urandom);
            else val = TENTHS_W'(int'($urandom_range(250)) - 50);
          end
          CFG_PCT: begin
            if (r == 0) val = '0;
            else if (r == 1) val = TENTHS_W'(PCT_FULL);
            else if (r == 2) val = TENTHS_W'(127);
            else if (r == 3) val = TENTHS_W'($urandom);
            else val = TENTHS_W'($urandom_range(100));
          end
          default: begin
            val = TENTHS_W'((ph != 7) && ($urandom_range(9) != 0));
            val[TENTHS_W-1:1] = (TENTHS_W-1)'($urandom);  // upper bits are ignored
          end
        endcase
        write_reg(ridx, val);
      end
      if (ph == 3) t = 32'hFFFF_FFFF - 32'($urandom_range(20000));
      idle_on = (ph != 5);
      for (int j = 0; j < PHASE_LEN; j++) begin
        r = $urandom_range(99);
        if (r < 70) t = t + 32'($urandom_range(300, 1));
        else if (r < 85) t = t + 32'($urandom_range(6000, 300));
        else if (r < 92) t = $urandom;
        else if (r < 96) t = t - 32'($urandom_range(3000, 1));
        else t = t + 32'h8000_0000 + 32'($urandom_range(2)) - 32'd1;
        r = $urandom_range(99);
        if (r < 70) d = 16'(int'($urandom_range(360)) - 100);
        else if (r < 78) d = 16'(zero_t + int'($urandom_range(2)) - 1);
        else if (r < 86) d = 16'(span_t + int'($urandom_range(2)) - 1);
        else if (r < 90) d = r[0] ? 16'sh7FFF : 16'sh8000;
        else d = 16'($urandom);
        bad = ($urandom_range(99) < 6);
        send_tick(t, d, bad, 1'b0, 1'b0);
      end
    end
    idle_on = 1'b1;

    @(negedge clk);
    in_valid = 1'b0;
    while (heat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("ran %0d ticks and %0d register writes over %0d setting phases",
             n_items, n_writes, PHASES);
    $display("heater was on in %0d results, %0d check failures", n_on, errors);
    if (errors == 0) begin
      $display("dew_heater_time_proportional_pwm_top regression: pass");
    end else begin
      $display("dew_heater_time_proportional_pwm_top regression: fail");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout with %0d heater items pending", heat_q.size());
    $display("dew_heater_time_proportional_pwm_top regression: fail");
    $finish;
  end

endmodule
